// ===== hw/rtl/gqd_pkg.sv =====
package gqd_pkg;

	// Width of the group rank carried on the command bus (GROUP_SIZE is at most 8).
	localparam int SEL_W = 3;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_FORM   = 2'd2,
		OP_UNUSED = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_ADDED     = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL      = 3'd2,
		ST_REMOVED   = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_MEMBER    = 3'd5,
		ST_TOO_FEW   = 3'd6
	} status_code_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic [15:0]        connection;
		logic signed [31:0] account;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [6:0]         position;
		logic [15:0]        member_connection;
		logic signed [31:0] member_account;
		logic [2:0]         member_index;
		logic               last;
		logic [6:0]         queued_count;
	} out_item_t;

	typedef struct packed {
		logic [15:0] connection;
		logic [31:0] account;
		logic [63:0] stamp;
	} entry_t;

	typedef struct packed {
		logic             load;
		logic             scan_start;
		logic             add_commit;
		logic             rem_commit;
		logic             pick_commit;
		logic             emit_rd;
		logic             res_load;
		status_code_t     res_status;
		logic             res_pos;
		logic             res_member;
		logic             res_last;
		logic [SEL_W-1:0] sel;
	} gqd_cmd_t;

	typedef struct packed {
		opcode_t op;
		logic    few;
		logic    scan_done;
		logic    dup;
		logic    has_free;
		logic    has_match;
		logic    out_free;
	} gqd_sts_t;

endpackage

// ===== hw/rtl/gqd_ctrl.sv =====
module gqd_ctrl import gqd_pkg::*; #(
	parameter int GROUP_SIZE = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  gqd_sts_t sts,
	output gqd_cmd_t cmd
);

	localparam int GP_W = $clog2(GROUP_SIZE);
	localparam logic [GP_W-1:0] LAST_PASS = GP_W'(GROUP_SIZE - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_DECIDE,
		S_RESULT,
		S_EMIT_RD,
		S_EMIT
	} state_t;

	state_t          state_q;
	logic [GP_W-1:0] pass_q;
	status_code_t    code_q;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.sel        = SEL_W'(pass_q);
		cmd.res_status = code_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = req_valid;
			end
			S_DECODE: begin
				unique case (sts.op)
					OP_ADD, OP_REMOVE: cmd.scan_start = 1'b1;
					OP_FORM:           cmd.scan_start = !sts.few;
					OP_UNUSED:         cmd.scan_start = 1'b0;
				endcase
			end
			S_SCAN: begin
			end
			S_DECIDE: begin
				unique case (sts.op)
					OP_ADD:    cmd.add_commit = !sts.dup && sts.has_free;
					OP_REMOVE: cmd.rem_commit = sts.has_match;
					OP_FORM: begin
						cmd.pick_commit = 1'b1;
						cmd.scan_start  = (pass_q != LAST_PASS);
					end
					OP_UNUSED: begin
					end
				endcase
			end
			S_RESULT: begin
				cmd.res_load = sts.out_free;
				cmd.res_pos  = (code_q == ST_ADDED);
				cmd.res_last = 1'b1;
			end
			S_EMIT_RD: begin
				cmd.emit_rd = 1'b1;
			end
			S_EMIT: begin
				cmd.res_load   = sts.out_free;
				cmd.res_member = 1'b1;
				cmd.res_last   = (pass_q == LAST_PASS);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pass_q  <= '0;
			code_q  <= ST_ADDED;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) state_q <= S_DECODE;
				end
				S_DECODE: begin
					pass_q <= '0;
					unique case (sts.op)
						OP_ADD, OP_REMOVE: state_q <= S_SCAN;
						OP_FORM: begin
							if (sts.few) begin
								code_q  <= ST_TOO_FEW;
								state_q <= S_RESULT;
							end else begin
								state_q <= S_SCAN;
							end
						end
						OP_UNUSED: state_q <= S_IDLE;
					endcase
				end
				S_SCAN: begin
					if (sts.scan_done) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					unique case (sts.op)
						OP_ADD: begin
							state_q <= S_RESULT;
							priority if (sts.dup) code_q <= ST_DUPLICATE;
							else if (!sts.has_free) code_q <= ST_FULL;
							else code_q <= ST_ADDED;
						end
						OP_REMOVE: begin
							state_q <= S_RESULT;
							code_q  <= sts.has_match ? ST_REMOVED : ST_NOT_FOUND;
						end
						OP_FORM: begin
							code_q <= ST_MEMBER;
							if (pass_q == LAST_PASS) begin
								pass_q  <= '0;
								state_q <= S_EMIT_RD;
							end else begin
								pass_q  <= pass_q + GP_W'(1);
								state_q <= S_SCAN;
							end
						end
						OP_UNUSED: state_q <= S_IDLE;
					endcase
				end
				S_RESULT: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (sts.out_free) begin
						if (pass_q == LAST_PASS) begin
							state_q <= S_IDLE;
						end else begin
							pass_q  <= pass_q + GP_W'(1);
							state_q <= S_EMIT_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/gqd_datapath.sv =====
module gqd_datapath import gqd_pkg::*; #(
	parameter int QUEUE_DEPTH = 64,
	parameter int GROUP_SIZE  = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  req,
	input  gqd_cmd_t  cmd,
	output gqd_sts_t  sts,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output out_item_t rsp
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int GP_W  = $clog2(GROUP_SIZE);
	localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

	// Latched request.
	opcode_t            op_q;
	logic [15:0]        conn_q;
	logic [31:0]        acct_q;

	// Slot store and its registered read port.
	entry_t             mem_q [QUEUE_DEPTH];
	entry_t             rd_s1;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic [IDX_W-1:0]   rd_addr;
	logic               rd_en;

	// Scan address generator.
	logic [IDX_W-1:0]   iss_q;
	logic               issuing_q;

	// Table state.
	logic [QUEUE_DEPTH-1:0] active_q;
	logic [CNT_W-1:0]   count_q;
	logic [63:0]        arrival_q;
	logic [IDX_W-1:0]   picked_q [GROUP_SIZE];

	// Scan results.
	logic               dup_q;
	logic               free_vld_q;
	logic [IDX_W-1:0]   free_idx_q;
	logic [CNT_W-1:0]   lt_cnt_q;
	logic               match_vld_q;
	logic [IDX_W-1:0]   match_idx_q;
	logic               best_vld_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [63:0]        best_stamp_q;

	logic               act_s1;
	logic               out_vld_q;
	logic               out_free;

	assign act_s1   = active_q[rd_idx_s1];
	assign out_free = !out_vld_q || !rsp_stall;

	assign rd_en   = issuing_q || cmd.emit_rd;
	assign rd_addr = issuing_q ? iss_q : picked_q[cmd.sel[GP_W-1:0]];

	always_comb begin
		sts.op        = op_q;
		sts.few       = CMP_W'(count_q) < CMP_W'(GROUP_SIZE);
		sts.scan_done = !issuing_q && !rd_vld_s1;
		sts.dup       = dup_q;
		sts.has_free  = free_vld_q;
		sts.has_match = match_vld_q;
		sts.out_free  = out_free;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			conn_q <= req.connection;
			acct_q <= req.account;
		end
		if (cmd.add_commit) mem_q[free_idx_q] <= '{conn_q, acct_q, arrival_q};
		if (rd_en) rd_s1 <= mem_q[rd_addr];
		rd_idx_s1 <= iss_q;
		if (cmd.pick_commit) picked_q[cmd.sel[GP_W-1:0]] <= best_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q      <= OP_UNUSED;
			iss_q     <= '0;
			issuing_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cmd.load) op_q <= opcode_t'(req.operation);
			rd_vld_s1 <= issuing_q;
			if (cmd.scan_start) begin
				iss_q     <= '0;
				issuing_q <= 1'b1;
			end else if (issuing_q) begin
				iss_q <= iss_q + IDX_W'(1);
				if (iss_q == IDX_W'(QUEUE_DEPTH - 1)) issuing_q <= 1'b0;
			end
		end
	end

	// One entry per cycle is folded into the running results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dup_q        <= 1'b0;
			free_vld_q   <= 1'b0;
			free_idx_q   <= '0;
			lt_cnt_q     <= '0;
			match_vld_q  <= 1'b0;
			match_idx_q  <= '0;
			best_vld_q   <= 1'b0;
			best_idx_q   <= '0;
			best_stamp_q <= '0;
		end else if (cmd.scan_start) begin
			dup_q       <= 1'b0;
			free_vld_q  <= 1'b0;
			lt_cnt_q    <= '0;
			match_vld_q <= 1'b0;
			best_vld_q  <= 1'b0;
		end else if (rd_vld_s1) begin
			if (act_s1 && rd_s1.account == acct_q) dup_q <= 1'b1;
			if (!act_s1 && !free_vld_q) begin
				free_vld_q <= 1'b1;
				free_idx_q <= rd_idx_s1;
			end
			if (act_s1 && rd_s1.stamp < arrival_q) lt_cnt_q <= lt_cnt_q + CNT_W'(1);
			if (act_s1 && rd_s1.connection == conn_q && !match_vld_q) begin
				match_vld_q <= 1'b1;
				match_idx_q <= rd_idx_s1;
			end
			if (act_s1 && (!best_vld_q || rd_s1.stamp < best_stamp_q)) begin
				best_vld_q   <= 1'b1;
				best_idx_q   <= rd_idx_s1;
				best_stamp_q <= rd_s1.stamp;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= '0;
			count_q   <= '0;
			arrival_q <= '0;
		end else begin
			if (cmd.add_commit) begin
				active_q[free_idx_q] <= 1'b1;
				count_q              <= count_q + CNT_W'(1);
				arrival_q            <= arrival_q + 64'd1;
			end else if (cmd.rem_commit) begin
				active_q[match_idx_q] <= 1'b0;
				count_q               <= count_q - CNT_W'(1);
			end else if (cmd.pick_commit) begin
				active_q[best_idx_q] <= 1'b0;
				count_q              <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_vld_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			rsp.status            <= cmd.res_status;
			rsp.position          <= cmd.res_pos ? 7'(lt_cnt_q + CNT_W'(1)) : 7'd0;
			rsp.member_connection <= cmd.res_member ? rd_s1.connection : 16'd0;
			rsp.member_account    <= cmd.res_member ? rd_s1.account : 32'd0;
			rsp.member_index      <= cmd.res_member ? cmd.sel : 3'd0;
			rsp.last              <= cmd.res_last;
			rsp.queued_count      <= 7'(count_q);
		end
	end

	assign rsp_valid = out_vld_q;

	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CNT_W'($countones(active_q)))
		else $error("queued count disagrees with active slots");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> out_free)
		else $error("result loaded over an untaken result");

	a_add_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.add_commit |-> (free_vld_q && !dup_q && !active_q[free_idx_q]))
		else $error("add written to an occupied slot");

	a_pick_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pick_commit |-> (best_vld_q && active_q[best_idx_q]))
		else $error("group pick without an active candidate");

endmodule

// ===== hw/rtl/grouping_queue_with_dedupe_core.sv =====
// Channel  | Direction | Handshake                 | Payload
// req      | in        | req_valid / req_stall     | in_item_t  (operation, connection, account)
// rsp      | out       | rsp_valid / rsp_stall     | out_item_t (status .. queued_count)
//
// An item is taken only while the controller is idle; for add, remove and a group
// with enough queued entries every slot is then scanned through the single read
// port of the slot store, one entry per cycle. Add and remove run a single scan;
// a group runs one scan per member.
// Reset (arst_n low) clears the active flags, the count and the arrival counter
// at once, so no clearing pass is needed.
// A stalled result holds in the output register; the controller waits there before
// loading the next result, while a finished result can still be taken.
module grouping_queue_with_dedupe_core import gqd_pkg::*; #(
	parameter int QUEUE_DEPTH = 64,
	parameter int GROUP_SIZE  = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  in_item_t  req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output out_item_t rsp
);

	gqd_cmd_t cmd;
	gqd_sts_t sts;

	// The controller sequences scans, commits and result loads.
	gqd_ctrl #(
		.GROUP_SIZE(GROUP_SIZE)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the slot store, the scan engine and the output register.
	gqd_datapath #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.GROUP_SIZE (GROUP_SIZE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

// Testbench for the grouping queue with duplicate rejection. Requests are
// offered on the req channel and every result on the rsp channel is compared
// against an in-bench model of the slot table. Directed rows come from a
// table; random traffic follows. Both sides idle at random, and one long
// stretch of back-pressure lets the block fill up and stall its input.
module tb;
	import gqd_pkg::*;

	localparam int DEPTH = 64;
	localparam int GSIZE = 4;
	localparam int RANDOM_ITEMS = 328;
	localparam int IDLE_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	in_item_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	out_item_t rsp;

	always #1 clk = ~clk;

	grouping_queue_with_dedupe_core #(.QUEUE_DEPTH(DEPTH), .GROUP_SIZE(GSIZE)) DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	// Model of the slot table.
	logic        mdl_active[DEPTH];
	logic [15:0] mdl_conn[DEPTH];
	logic [31:0] mdl_acct[DEPTH];
	logic [63:0] mdl_stamp[DEPTH];
	logic [63:0] mdl_arrivals;

	out_item_t pending_results[$];
	int errors = 0;
	bit quiet_phase = 0;   // no idling on either side
	bit hold_rsp = 0;      // long receiver hold-off
	int idle_cycles = 0;

	// Directed table: item, and an optional expected single result.
	typedef struct {
		in_item_t item;
		bit       has_exp;
		out_item_t exp;
	} row_t;
	row_t rows[$];

	function automatic int count_active();
		int n = 0;
		for (int i = 0; i < DEPTH; i++) if (mdl_active[i]) n++;
		return n;
	endfunction

	function automatic out_item_t short_result(status_code_t st, int pos);
		out_item_t r = '0;
		r.status = st;
		r.position = pos[6:0];
		r.last = 1'b1;
		r.queued_count = 7'(count_active());
		return r;
	endfunction

	// Applies one accepted request to the model and queues what it yields.
	task automatic predict_queue(input in_item_t it);
		int free_idx, pos, best, n;
		bit found;
		int picked[GSIZE];
		out_item_t r;
		free_idx = -1;
		case (opcode_t'(it.operation))
			OP_ADD: begin
				for (int i = 0; i < DEPTH; i++)
					if (mdl_active[i] && mdl_acct[i] == it.account) begin
						pending_results.push_back(short_result(ST_DUPLICATE, 0));
						return;
					end
				for (int i = 0; i < DEPTH; i++)
					if (!mdl_active[i] && free_idx < 0) free_idx = i;
				if (free_idx < 0) begin
					pending_results.push_back(short_result(ST_FULL, 0));
					return;
				end
				mdl_active[free_idx] = 1'b1;
				mdl_conn[free_idx] = it.connection;
				mdl_acct[free_idx] = it.account;
				mdl_stamp[free_idx] = mdl_arrivals;
				mdl_arrivals++;
				pos = 1;
				for (int i = 0; i < DEPTH; i++)
					if (mdl_active[i] && i != free_idx && mdl_stamp[i] < mdl_stamp[free_idx])
						pos++;
				pending_results.push_back(short_result(ST_ADDED, pos));
			end
			OP_REMOVE: begin
				for (int i = 0; i < DEPTH; i++)
					if (mdl_active[i] && mdl_conn[i] == it.connection) begin
						mdl_active[i] = 1'b0;
						pending_results.push_back(short_result(ST_REMOVED, 0));
						return;
					end
				pending_results.push_back(short_result(ST_NOT_FOUND, 0));
			end
			OP_FORM: begin
				if (count_active() < GSIZE) begin
					pending_results.push_back(short_result(ST_TOO_FEW, 0));
					return;
				end
				for (int p = 0; p < GSIZE; p++) begin
					found = 0;
					best = 0;
					for (int i = 0; i < DEPTH; i++)
						if (mdl_active[i] && (!found || mdl_stamp[i] < mdl_stamp[best])) begin
							best = i;
							found = 1;
						end
					picked[p] = best;
					mdl_active[best] = 1'b0;
				end
				n = count_active();
				for (int p = 0; p < GSIZE; p++) begin
					r = '0;
					r.status = ST_MEMBER;
					r.member_connection = mdl_conn[picked[p]];
					r.member_account = mdl_acct[picked[p]];
					r.member_index = 3'(p);
					r.last = (p == GSIZE - 1);
					r.queued_count = 7'(n);
					pending_results.push_back(r);
				end
			end
			default: ;
		endcase
	endtask

	// Offers one item and holds it until the block takes it. Valid stays high
	// after the accept until the next offer or an idle cycle replaces it.
	task automatic offer(input in_item_t it);
		while (!quiet_phase && $urandom_range(99) < 37) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= it;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		predict_queue(it);
	endtask

	function automatic in_item_t make_item(opcode_t op, logic [15:0] c, logic [31:0] a);
		in_item_t it;
		it.operation = op;
		it.connection = c;
		it.account = a;
		return it;
	endfunction

	// Adds a row; a typed-in expectation is given only for obvious cases.
	task automatic add_row(input in_item_t it, input bit has_exp, input out_item_t e);
		row_t r;
		r.item = it;
		r.has_exp = has_exp;
		r.exp = e;
		rows.push_back(r);
	endtask

	function automatic out_item_t typed(status_code_t st, int pos, int cnt);
		out_item_t r = '0;
		r.status = st;
		r.position = pos[6:0];
		r.last = 1'b1;
		r.queued_count = cnt[6:0];
		return r;
	endfunction

	// Random item, weighted toward a small pool of ids so that duplicates,
	// successful removes and full groups all occur often.
	function automatic in_item_t random_item();
		int sel = $urandom_range(99);
		logic [15:0] c;
		logic [31:0] a;
		opcode_t op;
		c = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40));
		a = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(60)) ^ 32'h8000_0000;
		if (sel < 50) op = OP_ADD;
		else if (sel < 72) op = OP_REMOVE;
		else if (sel < 97) op = OP_FORM;
		else op = OP_UNUSED;
		return make_item(op, c, a);
	endfunction

	// Receiver side: random stall, a quiet stretch, and one long hold-off.
	always @(posedge clk) begin
		if (hold_rsp) rsp_stall <= 1'b1;
		else if (quiet_phase) rsp_stall <= 1'b0;
		else rsp_stall <= ($urandom_range(99) < 37);
	end

	initial begin : hold_off
		wait (arst_n);
		repeat (3000) @(posedge clk);
		hold_rsp = 1;
		repeat (1500) @(posedge clk);
		hold_rsp = 0;
	end

	// Checks every accepted result against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %p", $realtime, rsp);
				errors++;
			end else begin
				out_item_t e;
				e = pending_results.pop_front();
				if (rsp.status !== e.status)
					$display("%0t: status expected %0d actual %0d", $realtime, e.status, rsp.status);
				if (rsp.position !== e.position)
					$display("%0t: position expected %0d actual %0d", $realtime, e.position,
						rsp.position);
				if (rsp.member_connection !== e.member_connection)
					$display("%0t: member_connection expected %h actual %h", $realtime,
						e.member_connection, rsp.member_connection);
				if (rsp.member_account !== e.member_account)
					$display("%0t: member_account expected %h actual %h", $realtime,
						e.member_account, rsp.member_account);
				if (rsp.member_index !== e.member_index)
					$display("%0t: member_index expected %0d actual %0d", $realtime,
						e.member_index, rsp.member_index);
				if (rsp.last !== e.last)
					$display("%0t: last expected %b actual %b", $realtime, e.last, rsp.last);
				if (rsp.queued_count !== e.queued_count)
					$display("%0t: queued_count expected %0d actual %0d", $realtime,
						e.queued_count, rsp.queued_count);
				if (rsp !== e) errors++;
			end
		end
	end

	// Watchdog: counts cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		out_item_t got;
		out_item_t none;
		none = '0;
		for (int i = 0; i < DEPTH; i++) mdl_active[i] = 1'b0;
		mdl_arrivals = '0;

		// After reset: an empty table gives too few, not found, then first add.
		add_row(make_item(OP_FORM, 16'h0, 32'h0), 1, typed(ST_TOO_FEW, 0, 0));
		add_row(make_item(OP_REMOVE, 16'hFFFF, 32'h0), 1, typed(ST_NOT_FOUND, 0, 0));
		add_row(make_item(OP_ADD, 16'hFFFF, 32'h7FFF_FFFF), 1, typed(ST_ADDED, 1, 1));
		add_row(make_item(OP_ADD, 16'h0000, 32'h8000_0000), 1, typed(ST_ADDED, 2, 2));
		add_row(make_item(OP_ADD, 16'h1234, 32'h7FFF_FFFF), 1, typed(ST_DUPLICATE, 0, 2));
		add_row(make_item(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF), 0, none);
		add_row(make_item(OP_ADD, 16'hAAAA, 32'hFFFF_FFFF), 0, none);
		add_row(make_item(OP_FORM, 16'hFFFF, 32'h5555_5555), 0, none);
		add_row(make_item(OP_ADD, 16'h5555, 32'h0000_0000), 0, none);
		add_row(make_item(OP_FORM, 16'h0, 32'h0), 0, none);
		// The group has emptied the table, so these removes find nothing and the adds take the lowest slots.
		add_row(make_item(OP_REMOVE, 16'hFFFF, 32'h0), 0, none);
		add_row(make_item(OP_ADD, 16'h0101, 32'h0000_0001), 0, none);
		add_row(make_item(OP_REMOVE, 16'h0000, 32'h0), 0, none);
		add_row(make_item(OP_ADD, 16'h0202, 32'h0000_0002), 0, none);
		add_row(make_item(OP_FORM, 16'h0, 32'h0), 0, none);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].has_exp) begin
				// The typed-in value must agree with the model's prediction too.
				predict_queue(rows[i].item);
				got = pending_results[$];
				void'(pending_results.pop_back());
				if (got !== rows[i].exp) begin
					$display("%0t: table row %0d expected %p model %p", $realtime, i,
						rows[i].exp, got);
					errors++;
				end
			end
		end
		// Reset the model and run the table for real.
		for (int i = 0; i < DEPTH; i++) mdl_active[i] = 1'b0;
		mdl_arrivals = '0;
		foreach (rows[i]) offer(rows[i].item);

		// Fill the table to hit the full case, with identical connections so
		// removes pick the lowest index.
		for (int i = 0; i < DEPTH + 2; i++)
			offer(make_item(OP_ADD, 16'h0777, 32'h4000_0000 + i));
		offer(make_item(OP_REMOVE, 16'h0777, 32'h0));

		// Random traffic with a stretch of no idling in the middle.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			quiet_phase = (n >= 150 && n < 230);
			offer(random_item());
		end
		req_valid <= 1'b0;
		quiet_phase = 0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
